// ----- design/eoq_pkg.sv -----
// Package for the elevator order queue: defaults, operation and direction codes, lane structs.
`default_nettype none
package eoq_pkg;

    // Default sizes of the queue.
    localparam int EOQ_FLOORS   = 4;
    localparam int EOQ_CAPACITY = 10;

    // Operation codes of a command word.
    localparam logic [1:0] OP_SCAN   = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Direction codes of an order, two's complement in two bits.
    localparam logic [1:0] DIR_CAB  = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    // Per-lane control from the sequencer.
    typedef struct packed {
        logic load;
        logic shift;
    } lane_ctl_t;

    // Per-lane compare results toward the merging stage.
    typedef struct packed {
        logic dup;
        logic del;
    } lane_hit_t;

endpackage
`default_nettype wire

// ----- design/eoq_in_if.sv -----
// Command channel of the elevator order queue: valid, ready and the command word.
`default_nettype none
interface eoq_in_if #(
    parameter int FLOORS = eoq_pkg::EOQ_FLOORS
);
    localparam int FLOOR_W = $clog2(FLOORS);

    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [FLOORS-1:0]         cab_buttons;
    logic [FLOORS-2:0]         up_buttons;
    logic [FLOORS-2:0]         down_buttons;
    logic signed [FLOOR_W:0]   sensed_floor;

    modport source (
        output valid, operation, cab_buttons, up_buttons, down_buttons, sensed_floor,
        input  ready
    );
    modport sink (
        input  valid, operation, cab_buttons, up_buttons, down_buttons, sensed_floor,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/eoq_out_if.sv -----
// Status channel of the elevator order queue: valid, ready and the status word.
`default_nettype none
interface eoq_out_if #(
    parameter int FLOORS   = eoq_pkg::EOQ_FLOORS,
    parameter int CAPACITY = eoq_pkg::EOQ_CAPACITY
);
    localparam int FLOOR_W = $clog2(FLOORS);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    logic                    valid;
    logic                    ready;
    logic [FLOORS-1:0]       cab_lamps_on;
    logic [FLOORS-2:0]       up_lamps_on;
    logic [FLOORS-2:0]       down_lamps_on;
    logic                    all_lamps_off;
    logic [CNT_W-1:0]        removed_count;
    logic                    dropped;
    logic [CNT_W-1:0]        order_count;
    logic                    head_valid;
    logic [FLOOR_W-1:0]      head_floor;
    logic signed [1:0]       head_direction;

    modport source (
        output valid, cab_lamps_on, up_lamps_on, down_lamps_on, all_lamps_off,
               removed_count, dropped, order_count, head_valid, head_floor, head_direction,
        input  ready
    );
    modport sink (
        input  valid, cab_lamps_on, up_lamps_on, down_lamps_on, all_lamps_off,
               removed_count, dropped, order_count, head_valid, head_floor, head_direction,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/eoq_lane.sv -----
// One queue lane: holds one order, compares it against the key and shifts or loads.
`default_nettype none
module eoq_lane #(
    parameter int FLOOR_W = $clog2(eoq_pkg::EOQ_FLOORS)
) (
    input  wire                  clk,
    input  eoq_pkg::lane_ctl_t   ctl,
    input  wire                  occupied,
    input  wire  [FLOOR_W-1:0]   key_floor,
    input  wire  [1:0]           key_dir,
    input  wire  [FLOOR_W-1:0]   next_floor,
    input  wire  [1:0]           next_dir,
    output logic [FLOOR_W-1:0]   entry_floor,
    output logic [1:0]           entry_dir,
    output eoq_pkg::lane_hit_t   hit
);

    logic [FLOOR_W-1:0] floor_reg;
    logic [1:0]         dir_reg;

    // Payload only; an unoccupied lane is never reported.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            floor_reg <= key_floor;
            dir_reg   <= key_dir;
        end
        else if (ctl.shift)
        begin
            floor_reg <= next_floor;
            dir_reg   <= next_dir;
        end
    end

    always_comb
    begin
        hit.del = occupied && (floor_reg == key_floor);
        hit.dup = hit.del && (dir_reg == key_dir);
    end

    assign entry_floor = floor_reg;
    assign entry_dir   = dir_reg;

endmodule
`default_nettype wire

// ----- design/eoq_merge.sv -----
// Merging stage: combines lane hits into a duplicate flag and a compaction mask.
`default_nettype none
module eoq_merge #(
    parameter int CAPACITY = eoq_pkg::EOQ_CAPACITY
) (
    input  eoq_pkg::lane_hit_t [CAPACITY-1:0] hits,
    output logic                              dup_any,
    output logic                              del_any,
    output logic [CAPACITY-1:0]               shift_mask
);

    // Every lane at or above the first floor match moves down by one.
    always_comb
    begin
        logic acc;
        acc     = 1'b0;
        dup_any = 1'b0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            acc           = acc | hits[j].del;
            shift_mask[j] = acc;
            dup_any       = dup_any | hits[j].dup;
        end
        del_any = acc;
    end

endmodule
`default_nettype wire

// ----- design/elevator_order_queue_core.sv -----
// Top level of the elevator order queue: sequencer, lane row and status register.
//
//  channel | modport | word
//  --------+---------+--------------------------------------------------------------
//  cmd     | sink    | operation, cab/up/down buttons, sensed floor
//  status  | source  | lamps on, all lamps off, removed, dropped, count, queue head
//
// A scan steps from the accepting cycle through the button slots in turn, each checked
// against every lane at once, then posts the status word. A delete removes the matching
// orders one at a time until none is left; a clear, an unused code or a delete between
// floors goes straight to the finish state. Reset empties the queue at once; the order
// store itself is never cleared. A command is taken while the previous status word waits;
// the next word is held back in the finish state until the status register is free.
`default_nettype none
module elevator_order_queue_core #(
    parameter int FLOORS   = eoq_pkg::EOQ_FLOORS,
    parameter int CAPACITY = eoq_pkg::EOQ_CAPACITY
) (
    input  wire        clk,
    input  wire        rst_n,
    eoq_in_if.sink     cmd,
    eoq_out_if.source  status
);

    localparam int FLOOR_W = $clog2(FLOORS);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STEPS   = 3 * FLOORS - 2;
    localparam int STEP_W  = $clog2(STEPS);

    // Button slots: cab floors first, then up calls, then down calls.
    localparam logic [STEP_W-1:0] UP_BASE   = STEP_W'(FLOORS);
    localparam logic [STEP_W-1:0] DN_BASE   = STEP_W'(2 * FLOORS - 1);
    localparam logic [STEP_W-1:0] DN_OFFSET = STEP_W'(2 * FLOORS - 2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam logic [CNT_W-1:0]  FULL      = CNT_W'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DELETE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // Work registers of the current command.
    logic [STEPS-1:0]   pend_reg, pend_next;
    logic [STEPS-1:0]   lamp_reg, lamp_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic               dropped_reg, dropped_next;
    logic               all_off_reg, all_off_next;
    logic [FLOOR_W-1:0] del_floor_reg, del_floor_next;

    // Status word register.
    logic [FLOORS-1:0]  cab_on_reg;
    logic [FLOORS-2:0]  up_on_reg;
    logic [FLOORS-2:0]  down_on_reg;
    logic               all_off_out_reg;
    logic [CNT_W-1:0]   removed_out_reg;
    logic               dropped_out_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               head_valid_reg;
    logic [FLOOR_W-1:0] head_floor_reg;
    logic [1:0]         head_dir_reg;

    // Lane row.
    eoq_pkg::lane_ctl_t [CAPACITY-1:0] lane_ctl;
    eoq_pkg::lane_hit_t [CAPACITY-1:0] lane_hit;
    logic [FLOOR_W-1:0] lane_floor [CAPACITY];
    logic [1:0]         lane_dir   [CAPACITY];
    logic [CAPACITY-1:0] shift_mask;
    logic               dup_any;
    logic               del_any;

    logic [FLOOR_W-1:0] slot_floor;
    logic [1:0]         slot_dir;
    logic [FLOOR_W-1:0] key_floor;
    logic               store_en;
    logic               shift_en;
    logic               post;
    logic               cmd_take;

    assign cmd_take  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    // Floor and direction of the button slot under scan.
    always_comb
    begin
        priority if (step_reg < UP_BASE)
        begin
            slot_floor = FLOOR_W'(step_reg);
            slot_dir   = eoq_pkg::DIR_CAB;
        end
        else if (step_reg < DN_BASE)
        begin
            slot_floor = FLOOR_W'(step_reg - UP_BASE);
            slot_dir   = eoq_pkg::DIR_UP;
        end
        else
        begin
            slot_floor = FLOOR_W'(step_reg - DN_OFFSET);
            slot_dir   = eoq_pkg::DIR_DOWN;
        end
    end

    assign key_floor = (state_reg == S_DELETE) ? del_floor_reg : slot_floor;

    // A pressed, new order is stored at the tail unless the queue is full.
    assign store_en = (state_reg == S_SCAN) && pend_reg[0] && !dup_any && (count_reg != FULL);
    assign shift_en = (state_reg == S_DELETE) && del_any;

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++)
        begin : g_lane
            logic [FLOOR_W-1:0] nfloor;
            logic [1:0]         ndir;

            if (j == CAPACITY - 1)
            begin : g_top
                assign nfloor = lane_floor[j];
                assign ndir   = lane_dir[j];
            end
            else
            begin : g_mid
                assign nfloor = lane_floor[j+1];
                assign ndir   = lane_dir[j+1];
            end

            assign lane_ctl[j].load  = store_en && (count_reg == CNT_W'(j));
            assign lane_ctl[j].shift = shift_en && shift_mask[j];

            eoq_lane #(
                .FLOOR_W (FLOOR_W)
            ) u_lane (
                .clk         (clk),
                .ctl         (lane_ctl[j]),
                .occupied    (CNT_W'(j) < count_reg),
                .key_floor   (key_floor),
                .key_dir     (slot_dir),
                .next_floor  (nfloor),
                .next_dir    (ndir),
                .entry_floor (lane_floor[j]),
                .entry_dir   (lane_dir[j]),
                .hit         (lane_hit[j])
            );
        end
    endgenerate

    eoq_merge #(
        .CAPACITY (CAPACITY)
    ) u_merge (
        .hits       (lane_hit),
        .dup_any    (dup_any),
        .del_any    (del_any),
        .shift_mask (shift_mask)
    );

    // The status register is free when empty or when its word is being taken.
    assign post = (state_reg == S_FINISH) && (!out_valid_reg || status.ready);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        lamp_next      = lamp_reg;
        removed_next   = removed_reg;
        dropped_next   = dropped_reg;
        all_off_next   = all_off_reg;
        del_floor_next = del_floor_reg;

        if (out_valid_reg && status.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    pend_next      = {cmd.down_buttons, cmd.up_buttons, cmd.cab_buttons};
                    lamp_next      = '0;
                    removed_next   = '0;
                    dropped_next   = 1'b0;
                    all_off_next   = 1'b0;
                    step_next      = '0;
                    del_floor_next = cmd.sensed_floor[FLOOR_W-1:0];
                    unique case (cmd.operation)
                        eoq_pkg::OP_SCAN:
                        begin
                            state_next = S_SCAN;
                        end
                        eoq_pkg::OP_DELETE:
                        begin
                            // A negative sensor reading matches nothing.
                            state_next = cmd.sensed_floor[FLOOR_W] ? S_FINISH : S_DELETE;
                        end
                        eoq_pkg::OP_CLEAR:
                        begin
                            removed_next = count_reg;
                            count_next   = '0;
                            all_off_next = 1'b1;
                            state_next   = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Lamp bits shift in from the top and line up with the slots at the end.
                lamp_next = {store_en, lamp_reg[STEPS-1:1]};
                pend_next = pend_reg >> 1;
                if (store_en)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (pend_reg[0] && !dup_any && (count_reg == FULL))
                begin
                    dropped_next = 1'b1;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DELETE:
            begin
                // One matching order leaves per cycle; the lanes above it close the gap.
                if (del_any)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (post)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        lamp_reg      <= lamp_next;
        removed_reg   <= removed_next;
        dropped_reg   <= dropped_next;
        all_off_reg   <= all_off_next;
        del_floor_reg <= del_floor_next;
    end

    // Status word, loaded when the command finishes.
    always_ff @(posedge clk)
    begin
        if (post)
        begin
            cab_on_reg      <= lamp_reg[FLOORS-1:0];
            up_on_reg       <= lamp_reg[2*FLOORS-2:FLOORS];
            down_on_reg     <= lamp_reg[STEPS-1:2*FLOORS-1];
            all_off_out_reg <= all_off_reg;
            removed_out_reg <= removed_reg;
            dropped_out_reg <= dropped_reg;
            count_out_reg   <= count_reg;
            head_valid_reg  <= (count_reg != '0);
            head_floor_reg  <= (count_reg != '0) ? lane_floor[0] : '0;
            head_dir_reg    <= (count_reg != '0) ? lane_dir[0] : eoq_pkg::DIR_CAB;
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.cab_lamps_on   = cab_on_reg;
    assign status.up_lamps_on    = up_on_reg;
    assign status.down_lamps_on  = down_on_reg;
    assign status.all_lamps_off  = all_off_out_reg;
    assign status.removed_count  = removed_out_reg;
    assign status.dropped        = dropped_out_reg;
    assign status.order_count    = count_out_reg;
    assign status.head_valid     = head_valid_reg;
    assign status.head_floor     = head_floor_reg;
    assign status.head_direction = head_dir_reg;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the elevator order queue core.
`timescale 1ns / 1ps
module testbench;

    localparam int FLOORS   = eoq_pkg::EOQ_FLOORS;
    localparam int CAPACITY = eoq_pkg::EOQ_CAPACITY;
    localparam int FLOOR_W  = $clog2(FLOORS);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // The block has no meaning for this selector; it must only report the queue state.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One command word as it travels on the cmd channel.
    typedef struct packed {
        logic [1:0]              operation;
        logic [FLOORS-1:0]       cab_buttons;
        logic [FLOORS-2:0]       up_buttons;
        logic [FLOORS-2:0]       down_buttons;
        logic signed [FLOOR_W:0] sensed_floor;
    } cmd_word_t;

    // One status word as it travels on the status channel.
    typedef struct packed {
        logic [FLOORS-1:0]  cab_lamps_on;
        logic [FLOORS-2:0]  up_lamps_on;
        logic [FLOORS-2:0]  down_lamps_on;
        logic               all_lamps_off;
        logic [CNT_W-1:0]   removed_count;
        logic               dropped;
        logic [CNT_W-1:0]   order_count;
        logic               head_valid;
        logic [FLOOR_W-1:0] head_floor;
        logic [1:0]         head_direction;
    } status_word_t;

    // A row of the directed table. When fixed is set, the status word below is the
    // answer read straight off the behavior; otherwise the predictor supplies it.
    typedef struct {
        cmd_word_t    cmd;
        bit           fixed;
        status_word_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    eoq_in_if  cmd_if ();
    eoq_out_if status_if ();

    elevator_order_queue_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .status (status_if)
    );

    // The testbench's own copy of the queue: floor and direction of every held order,
    // oldest first, and the number of orders held.
    logic [FLOOR_W-1:0] held_floor [CAPACITY];
    logic [1:0]         held_dir   [CAPACITY];
    int                 held_n = 0;

    // Status words predicted for accepted commands, oldest first.
    status_word_t status_due [$];

    stim_row_t directed_rows [$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Appends an order unless it is already held. A new order that finds the queue
    // full is lost and flags it; scanning goes on, so later duplicates still match.
    function automatic bit offer_order(input int floor_no, input logic [1:0] dir,
                                       inout logic lost);
        for (int i = 0; i < held_n; i++) begin
            if (held_floor[i] == FLOOR_W'(floor_no) && held_dir[i] == dir)
                return 1'b0;
        end
        if (held_n >= CAPACITY) begin
            lost = 1'b1;
            return 1'b0;
        end
        held_floor[held_n] = FLOOR_W'(floor_no);
        held_dir[held_n]   = dir;
        held_n++;
        return 1'b1;
    endfunction

    // Applies one command word to the queue copy and returns the status word it yields.
    function automatic status_word_t advance_order_queue(input cmd_word_t c);
        status_word_t s;
        logic         lost;
        int           w;
        s    = '0;
        lost = 1'b0;
        case (c.operation)
            eoq_pkg::OP_SCAN: begin
                // Button order is fixed: cab floors upward, then up calls, then down calls.
                for (int f = 0; f < FLOORS; f++) begin
                    if (c.cab_buttons[f] && offer_order(f, eoq_pkg::DIR_CAB, lost))
                        s.cab_lamps_on[f] = 1'b1;
                end
                for (int f = 0; f < FLOORS - 1; f++) begin
                    if (c.up_buttons[f] && offer_order(f, eoq_pkg::DIR_UP, lost))
                        s.up_lamps_on[f] = 1'b1;
                end
                for (int f = 1; f < FLOORS; f++) begin
                    if (c.down_buttons[f-1] && offer_order(f, eoq_pkg::DIR_DOWN, lost))
                        s.down_lamps_on[f-1] = 1'b1;
                end
                s.dropped = lost;
            end
            eoq_pkg::OP_DELETE: begin
                // A negative reading means the car is between floors: nothing goes.
                if (!c.sensed_floor[FLOOR_W]) begin
                    w = 0;
                    for (int i = 0; i < held_n; i++) begin
                        if (held_floor[i] == c.sensed_floor[FLOOR_W-1:0]) begin
                            s.removed_count = s.removed_count + 1'b1;
                        end else begin
                            held_floor[w] = held_floor[i];
                            held_dir[w]   = held_dir[i];
                            w++;
                        end
                    end
                    held_n = w;
                end
            end
            eoq_pkg::OP_CLEAR: begin
                s.removed_count = CNT_W'(held_n);
                s.all_lamps_off = 1'b1;
                held_n          = 0;
            end
            default: ;
        endcase
        s.order_count = CNT_W'(held_n);
        if (held_n > 0) begin
            s.head_valid     = 1'b1;
            s.head_floor     = held_floor[0];
            s.head_direction = held_dir[0];
        end
        return s;
    endfunction

    // Random command word. Most words are scans and deletes at real floors, so the queue
    // keeps filling and draining; clears, readings between floors and the unused
    // selector are mixed in less often.
    function automatic cmd_word_t random_command();
        cmd_word_t c;
        int        pick;
        c.cab_buttons  = FLOORS'($urandom);
        c.up_buttons   = (FLOORS-1)'($urandom);
        c.down_buttons = (FLOORS-1)'($urandom);
        c.sensed_floor = (FLOOR_W+1)'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
            c.operation = eoq_pkg::OP_SCAN;
            // Half of the scans press only a few buttons, so the queue grows in steps.
            if ($urandom_range(1) == 1) begin
                c.cab_buttons  &= FLOORS'($urandom);
                c.up_buttons   &= (FLOORS-1)'($urandom);
                c.down_buttons &= (FLOORS-1)'($urandom);
            end
        end else if (pick < 88) begin
            c.operation = eoq_pkg::OP_DELETE;
            if ($urandom_range(9) != 0)
                c.sensed_floor = (FLOOR_W+1)'($urandom_range(FLOORS - 1));
        end else if (pick < 96) begin
            c.operation = eoq_pkg::OP_CLEAR;
        end else begin
            c.operation = OP_UNUSED;
        end
        return c;
    endfunction

    function automatic void report_mismatch(input string what, input status_word_t want,
                                            input status_word_t seen);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] status mismatch (%s): expected %h, got %h", $realtime, what,
                     want, seen);
    endfunction

    // Offers one command word, after a random idle gap drawn from the current phase,
    // and holds it until the block takes it. The status word due for it is queued at
    // the edge of acceptance.
    task automatic send_word(input cmd_word_t c, input bit fixed, input status_word_t want);
        status_word_t predicted;
        int           gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= c.operation;
        cmd_if.cab_buttons  <= c.cab_buttons;
        cmd_if.up_buttons   <= c.up_buttons;
        cmd_if.down_buttons <= c.down_buttons;
        cmd_if.sensed_floor <= c.sensed_floor;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        // The predictor always runs so that its queue copy tracks the block, even for
        // rows whose answer is typed into the table.
        predicted = advance_order_queue(c);
        status_due.push_back(fixed ? want : predicted);
    endtask

    // Withdraws the command word and waits until every status word due has arrived.
    task automatic pause_until_drained();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: stalls at random with the rate of the current phase. A long hold-off,
    // requested by the main sequence, is counted down here cycle by cycle.
    initial begin
        status_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                status_if.ready <= 1'b0;
            end else begin
                status_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Every status word taken is compared with the oldest one due, field by field.
    always @(posedge clk) begin : status_check
        status_word_t seen;
        status_word_t want;
        string        diff;
        if (rst_n && status_if.valid && status_if.ready) begin
            seen = '{status_if.cab_lamps_on, status_if.up_lamps_on, status_if.down_lamps_on,
                     status_if.all_lamps_off, status_if.removed_count, status_if.dropped,
                     status_if.order_count, status_if.head_valid, status_if.head_floor,
                     status_if.head_direction};
            if (status_due.size() == 0) begin
                report_mismatch("word with nothing outstanding", '0, seen);
            end else begin
                want = status_due.pop_front();
                diff = "";
                if (seen.cab_lamps_on !== want.cab_lamps_on)   diff = {diff, " cab_lamps_on"};
                if (seen.up_lamps_on !== want.up_lamps_on)     diff = {diff, " up_lamps_on"};
                if (seen.down_lamps_on !== want.down_lamps_on) diff = {diff, " down_lamps_on"};
                if (seen.all_lamps_off !== want.all_lamps_off) diff = {diff, " all_lamps_off"};
                if (seen.removed_count !== want.removed_count) diff = {diff, " removed_count"};
                if (seen.dropped !== want.dropped)             diff = {diff, " dropped"};
                if (seen.order_count !== want.order_count)     diff = {diff, " order_count"};
                if (seen.head_valid !== want.head_valid)       diff = {diff, " head_valid"};
                if (seen.head_floor !== want.head_floor)       diff = {diff, " head_floor"};
                if (seen.head_direction !== want.head_direction)
                    diff = {diff, " head_direction"};
                if (diff != "")
                    report_mismatch({"field", diff}, want, seen);
            end
        end
    end

    // Hard stop in case a handshake never completes. The slowest correct run, a few hundred
    // words, stays far below this.
    initial begin
        #800_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        // All inputs are known from time zero, while the block is held in reset.
        rst_n                  = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.operation       = eoq_pkg::OP_SCAN;
        cmd_if.cab_buttons     = '0;
        cmd_if.up_buttons      = '0;
        cmd_if.down_buttons    = '0;
        cmd_if.sensed_floor    = '0;

        // Directed table. After reset the queue is empty. Pressing every button fills it
        // with all ten distinct orders, which is exactly the capacity at the default size,
        // so a scan into the full queue only meets duplicates and nothing is dropped.
        // Order in the full queue: cab 0..3, up 0..2, down 1..3.
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd0, 1'b0, 2'd0, eoq_pkg::DIR_CAB}});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd0, 1'b0, 2'd0, eoq_pkg::DIR_CAB}});
        // The unused selector with every button pressed must leave the queue alone.
        directed_rows.push_back('{'{OP_UNUSED, 4'hF, 3'h7, 3'h7, 3'sd3}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd0, 1'b0, 2'd0, eoq_pkg::DIR_CAB}});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'hF, 3'h7, 3'h7, 3'sd0}, 1'b1,
            '{4'hF, 3'h7, 3'h7, 1'b0, 4'd0, 1'b0, 4'd10, 1'b1, 2'd0, eoq_pkg::DIR_CAB}});
        // Full queue, every order a duplicate: no lamp, no drop.
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'hF, 3'h7, 3'h7, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd10, 1'b1, 2'd0, eoq_pkg::DIR_CAB}});
        // Readings between floors remove nothing.
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, -3'sd1}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd10, 1'b1, 2'd0, eoq_pkg::DIR_CAB}});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'hF, 3'h7, 3'h7, 3'sb100}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd0, 1'b0, 4'd10, 1'b1, 2'd0, eoq_pkg::DIR_CAB}});
        // Floor 0 holds cab 0 and up 0; the head moves to cab 1.
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd2, 1'b0, 4'd8, 1'b1, 2'd1, eoq_pkg::DIR_CAB}});
        // Floor 3 holds cab 3 and down 3.
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd3}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b0, 4'd2, 1'b0, 4'd6, 1'b1, 2'd1, eoq_pkg::DIR_CAB}});
        directed_rows.push_back('{'{eoq_pkg::OP_CLEAR, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b1, 4'd6, 1'b0, 4'd0, 1'b0, 2'd0, eoq_pkg::DIR_CAB}});
        // Clearing an empty queue still switches the lamps off.
        directed_rows.push_back('{'{eoq_pkg::OP_CLEAR, 4'hF, 3'h7, 3'h7, -3'sd1}, 1'b1,
            '{4'h0, 3'h0, 3'h0, 1'b1, 4'd0, 1'b0, 4'd0, 1'b0, 2'd0, eoq_pkg::DIR_CAB}});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'h0, 3'h0, 3'h4, 3'sd0}, 1'b1,
            '{4'h0, 3'h0, 3'h4, 1'b0, 4'd0, 1'b0, 4'd1, 1'b1, 2'd3, eoq_pkg::DIR_DOWN}});
        // From here on the predictor supplies the answers.
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'h8, 3'h1, 3'h0, 3'sd0}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'h9, 3'h0, 3'h5, 3'sd0}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd3}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd2}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'h6, 3'h6, 3'h2, 3'sd0}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, -3'sd2}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd1}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_SCAN, 4'hF, 3'h7, 3'h7, 3'sd0}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_DELETE, 4'h0, 3'h0, 3'h0, 3'sd1}, 1'b0, '0});
        directed_rows.push_back('{'{OP_UNUSED, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b0, '0});
        directed_rows.push_back('{'{eoq_pkg::OP_CLEAR, 4'h0, 3'h0, 3'h0, 3'sd0}, 1'b0, '0});

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // The directed words run with light idling on both sides.
        send_idle_pct = 13;
        stall_pct     = 13;
        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);

        // First random phase: no idling at all. Part way through, the receiver holds off
        // for a long stretch while words keep coming, so the status register stays
        // occupied and the block must stall its command side.
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int n = 0; n < 100; n++) begin
            if (n == 30)
                hold_left = 300;
            send_word(random_command(), 1'b0, '0);
        end

        // Sender idle most of the time, receiver always ready.
        send_idle_pct = 68;
        stall_pct     = 0;
        for (int n = 0; n < 100; n++)
            send_word(random_command(), 1'b0, '0);

        // The sender stops until the queue of due status words is empty, then the
        // receiver stalls most of the time against a sender that never idles.
        pause_until_drained();
        send_idle_pct = 0;
        stall_pct     = 68;
        for (int n = 0; n < 100; n++)
            send_word(random_command(), 1'b0, '0);

        // Light idling on both sides.
        send_idle_pct = 13;
        stall_pct     = 13;
        for (int n = 0; n < 100; n++)
            send_word(random_command(), 1'b0, '0);

        // Wait for the last status word, then watch a while for anything extra.
        pause_until_drained();
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
